@@ rtl/ihf_pkg.sv @@
`default_nettype none

package ihf_pkg;

	localparam int unsigned CFG_W = 12;
	localparam int unsigned CH_W  = 8;
	localparam int unsigned RGB_W = 3 * CH_W;

	// Red in the lowest byte, then green, then blue.
	typedef logic [RGB_W-1:0] rgb_t;

	localparam rgb_t WHITE_RGB = {RGB_W{1'b1}};

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef struct packed {
		rgb_t upper;
		rgb_t middle;
	} line_pair_t;

	typedef struct packed {
		rgb_t pix;
		logic emit;
		logic last;
		logic left_ok;
		logic right_ok;
		logic top_ok;
		logic bot_ok;
	} s1_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/ihf_line_buf.sv @@
`default_nettype none

module ihf_line_buf #(
	parameter int DEPTH = 2048
) (
	input  wire logic                                clk,
	input  wire logic                                rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]            rd_addr,
	input  wire logic                                wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]            wr_addr,
	input  wire ihf_pkg::line_pair_t                 wr_data,
	output      ihf_pkg::line_pair_t                 rd_data
);

	ihf_pkg::line_pair_t mem [DEPTH];
	ihf_pkg::line_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A write to the address being read in the same cycle is forwarded.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/image_hole_fill_3x3.sv @@
// Stage 1 holds a request and its line store read; the output register holds the result;
// results trail the pixel stream by frame_width+1 requests.
// Throughput: one request per cycle if not stalled, set by one line store read and write.
// Reset: counters, window, pipeline valids and configuration (640 x 480) clear at once;
// the line stores are left uninitialized and need no clearing pass.
`default_nettype none

module image_hole_fill_3x3 #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [ihf_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        s_tvalid,
	output      logic                        s_tready,
	input  wire logic [23:0]                 s_tdata,   // in_red, in_green, in_blue
	input  wire logic                        s_tuser,   // opcode
	output      logic                        m_tvalid,
	input  wire logic                        m_tready,
	output      logic [23:0]                 m_tdata,   // out_red, out_green, out_blue
	output      logic                        m_tuser,   // was_filled
	output      logic                        m_tlast
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);

	logic [ihf_pkg::CFG_W-1:0] width_q;
	logic [ihf_pkg::CFG_W-1:0] height_q;
	logic [WW-1:0]             w_eff;
	logic [HW-1:0]             h_eff;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic               flush;
	logic               load;
	logic               adv;
	logic               s1_go;
	logic [WW-1:0]      col_inc;
	logic               wrap;
	logic [CW-1:0]      qx;
	logic [RW-1:0]      qy;
	ihf_pkg::s1_ctrl_t  ctrl_d;

	logic               valid_s1;
	ihf_pkg::s1_ctrl_t  ctrl_s1;
	logic [CW-1:0]      addr_s1;

	ihf_pkg::line_pair_t rd_pair;
	ihf_pkg::line_pair_t wr_pair;

	ihf_pkg::rgb_t win_q [2][3];
	ihf_pkg::rgb_t cand [8];
	logic [7:0]    cand_ok;
	ihf_pkg::rgb_t res;
	logic          filled;

	logic          out_valid_q;
	ihf_pkg::rgb_t out_pix_q;
	logic          out_filled_q;
	logic          out_last_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ihf_pkg::CFG_W'(640);
			height_q <= ihf_pkg::CFG_W'(480);
		end else if (cfg_we) begin
			case (ihf_pkg::reg_index_t'(cfg_index))
				ihf_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
				ihf_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	// Input side: position, flush handling and border flags of the result pixel.
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign s1_go    = valid_s1 && adv;

	assign flush   = (row_q >= RW'(h_eff));
	assign load    = s_tvalid && s_tready
		&& (flush || (ihf_pkg::opcode_t'(s_tuser) != ihf_pkg::OP_FLUSH));
	assign col_inc = WW'(col_q) + WW'(1);
	assign wrap    = (col_inc >= w_eff);

	always_comb begin
		if (col_q != '0) begin
			qx = col_q - CW'(1);
			qy = row_q - RW'(1);
		end else begin
			qx = CW'(w_eff - WW'(1));
			qy = row_q - RW'(2);
		end
		ctrl_d.pix      = flush ? ihf_pkg::WHITE_RGB : ihf_pkg::rgb_t'(s_tdata);
		ctrl_d.emit     = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
		ctrl_d.last     = ctrl_d.emit && (WW'(qx) == (w_eff - WW'(1)))
			&& (qy == (RW'(h_eff) - RW'(1)));
		ctrl_d.left_ok  = (qx != '0);
		ctrl_d.right_ok = ((WW'(qx) + WW'(1)) < w_eff);
		ctrl_d.top_ok   = (qy != '0);
		ctrl_d.bot_ok   = ((qy + RW'(1)) < RW'(h_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (load) begin
			if (ctrl_d.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctrl_s1 <= ctrl_d;
			addr_s1 <= col_q;
		end
	end

	assign wr_pair.upper  = rd_pair.middle;
	assign wr_pair.middle = ctrl_s1.pix;

	ihf_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.rd_en  (load),
		.rd_addr(col_q),
		.wr_en  (s1_go),
		.wr_addr(addr_s1),
		.wr_data(wr_pair),
		.rd_data(rd_pair)
	);

	// Window: the two newest columns are held; new column: line stores above the input pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int x = 0; x < 2; x++) begin
				for (int y = 0; y < 3; y++) begin
					win_q[x][y] <= '0;
				end
			end
		end else if (s1_go) begin
			for (int y = 0; y < 3; y++) begin
				win_q[0][y] <= win_q[1][y];
			end
			win_q[1][0] <= rd_pair.upper;
			win_q[1][1] <= rd_pair.middle;
			win_q[1][2] <= ctrl_s1.pix;
		end
	end

	// Neighbors in column-major order, the center left out.
	always_comb begin
		cand[0] = win_q[0][0];
		cand[1] = win_q[0][1];
		cand[2] = win_q[0][2];
		cand[3] = win_q[1][0];
		cand[4] = win_q[1][2];
		cand[5] = rd_pair.upper;
		cand[6] = rd_pair.middle;
		cand[7] = ctrl_s1.pix;
		cand_ok[0] = ctrl_s1.left_ok && ctrl_s1.top_ok;
		cand_ok[1] = ctrl_s1.left_ok;
		cand_ok[2] = ctrl_s1.left_ok && ctrl_s1.bot_ok;
		cand_ok[3] = ctrl_s1.top_ok;
		cand_ok[4] = ctrl_s1.bot_ok;
		cand_ok[5] = ctrl_s1.right_ok && ctrl_s1.top_ok;
		cand_ok[6] = ctrl_s1.right_ok;
		cand_ok[7] = ctrl_s1.right_ok && ctrl_s1.bot_ok;
	end

	always_comb begin
		res    = win_q[1][1];
		filled = 1'b0;
		if (win_q[1][1] == ihf_pkg::WHITE_RGB) begin
			for (int i = 7; i >= 0; i--) begin
				if (cand_ok[i] && (cand[i] != ihf_pkg::WHITE_RGB)) begin
					res    = cand[i];
					filled = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_go && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_pix_q    <= res;
			out_filled_q <= filled;
			out_last_q   <= ctrl_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tuser  = out_filled_q;
	assign m_tlast  = out_last_q;

	a_filled_not_white: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata != ihf_pkg::WHITE_RGB))
		else $error("filled result carries white");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(addr_s1))
		else $error("stage 1 request lost while output stalled");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (col_q == '0) && (row_q == '0))
		else $error("register write did not restart the frame");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= (RW'(h_eff) + RW'(1)))
		else $error("row count ran past the flush rows");

endmodule

`default_nettype wire
